### hdl/rsnp_pkg.sv
package rsnp_pkg;

    // Default accumulator width and width of the reported value
    localparam int VALUE_BITS_DEF = 16;
    localparam int OUT_BITS       = 16;

    // Queue depth between the front and back, and in front of the result ports
    localparam int QUEUE_DEPTH = 2;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_Q     = 8'h51;

    // Radix codes as reported on radix_code
    localparam logic [1:0] RC_BIN = 2'd0;
    localparam logic [1:0] RC_OCT = 2'd1;
    localparam logic [1:0] RC_DEC = 2'd2;
    localparam logic [1:0] RC_HEX = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_new;
    } in_item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                number_ok;
        logic [1:0]          radix_code;
        logic                char_consumed;
    } out_item_t;

    // Character after classification by the front end
    typedef struct packed {
        logic       start_new;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_h;
        logic       is_oq;
        logic       is_b;
        logic       is_d;
    } cls_item_t;

endpackage

### hdl/rsnp_fifo.sv
module rsnp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rsnp_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/rsnp_front.sv
module rsnp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rsnp_pkg::in_item_t  item,
    output logic                full,
    input  logic                pop,
    output rsnp_pkg::cls_item_t cls,
    output logic                empty
);

    rsnp_pkg::cls_item_t cls_in;
    logic [7:0]          c;
    logic                is_num;
    logic                is_hexl;

    assign c       = item.char_code;
    assign is_num  = (c >= rsnp_pkg::CH_0) && (c <= rsnp_pkg::CH_9);
    assign is_hexl = (c >= rsnp_pkg::CH_A) && (c <= rsnp_pkg::CH_F);

    always_comb
    begin
        cls_in.start_new = item.start_new;
        cls_in.is_space  = (c == rsnp_pkg::CH_SPACE);
        cls_in.is_digit  = is_num || is_hexl;
        // 'A'..'F' map to 10..15: low nibble plus 9
        cls_in.digit     = is_num ? c[3:0] : c[3:0] + 4'd9;
        cls_in.is_h      = (c == rsnp_pkg::CH_H);
        cls_in.is_oq     = (c == rsnp_pkg::CH_O) || (c == rsnp_pkg::CH_Q);
        cls_in.is_b      = (c == rsnp_pkg::CH_B);
        cls_in.is_d      = (c == rsnp_pkg::CH_D);
    end

    rsnp_fifo #(
        .WIDTH ($bits(rsnp_pkg::cls_item_t)),
        .DEPTH (rsnp_pkg::QUEUE_DEPTH)
    ) u_cls_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls_in),
        .full    (full),
        .pop     (pop),
        .rd_data (cls),
        .empty   (empty)
    );

endmodule

### hdl/rsnp_back.sv
module rsnp_back #(
    parameter int VALUE_BITS = rsnp_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rsnp_pkg::cls_item_t cls,
    input  logic                cls_empty,
    output logic                cls_pop,
    output rsnp_pkg::out_item_t res,
    output logic                res_push,
    input  logic                res_full
);

    localparam int VB    = VALUE_BITS;
    localparam int OUT_W = rsnp_pkg::OUT_BITS;

    // acc * radix + d, with four guard bits to catch overflow
    function automatic logic [VB+3:0] scale_add(
        input logic [VB-1:0] acc,
        input logic [1:0]    rsel,
        input logic [3:0]    d
    );
        logic [VB+3:0] a;
        logic [VB+3:0] s;
        a = {4'b0000, acc};
        unique case (rsel)
            rsnp_pkg::RC_BIN: s = a << 1;
            rsnp_pkg::RC_OCT: s = a << 3;
            rsnp_pkg::RC_DEC: s = (a << 3) + (a << 1);
            default:          s = a << 4;
        endcase
        return s + {{VB{1'b0}}, d};
    endfunction

    function automatic logic digit_bad(input logic [1:0] rsel, input logic [3:0] d);
        logic bad;
        unique case (rsel)
            rsnp_pkg::RC_BIN: bad = |d[3:1];
            rsnp_pkg::RC_OCT: bad = d[3];
            rsnp_pkg::RC_DEC: bad = (d > 4'd9);
            default:          bad = 1'b0;
        endcase
        return bad;
    endfunction

    logic          run_reg,      run_next;
    logic [VB-1:0] bin_acc_reg,  bin_acc_next;
    logic [VB-1:0] oct_acc_reg,  oct_acc_next;
    logic [VB-1:0] dec_acc_reg,  dec_acc_next;
    logic [VB-1:0] hex_acc_reg,  hex_acc_next;
    logic [VB-1:0] bin_prev_reg, bin_prev_next;
    logic [VB-1:0] dec_prev_reg, dec_prev_next;
    logic [3:0]    fail_reg,     fail_next;       // bit0 bin, 1 oct, 2 dec, 3 hex
    logic [1:0]    fail_prev_reg, fail_prev_next; // bit0 bin, 1 dec
    logic          last_b_reg,   last_b_next;
    logic          last_d_reg,   last_d_next;

    // state as seen by this character (start_new clears it first)
    logic          cur_run;
    logic [VB-1:0] cur_bin, cur_oct, cur_dec, cur_hex, cur_bin_prev, cur_dec_prev;
    logic [3:0]    cur_fail;
    logic [1:0]    cur_fail_prev;
    logic          cur_last_b, cur_last_d;

    logic [VB+3:0] bin_w, oct_w, dec_w, hex_w;
    logic [3:0]    stop;
    logic          take, skip, ending;
    logic [VB-1:0] sel_v;
    logic          sel_ok;
    logic [1:0]    sel_rc;
    logic          sel_used;
    logic [OUT_W-1:0] sel_v16;

    assign cur_run       = cls.start_new ? 1'b0 : run_reg;
    assign cur_bin       = cls.start_new ? '0 : bin_acc_reg;
    assign cur_oct       = cls.start_new ? '0 : oct_acc_reg;
    assign cur_dec       = cls.start_new ? '0 : dec_acc_reg;
    assign cur_hex       = cls.start_new ? '0 : hex_acc_reg;
    assign cur_bin_prev  = cls.start_new ? '0 : bin_prev_reg;
    assign cur_dec_prev  = cls.start_new ? '0 : dec_prev_reg;
    assign cur_fail      = cls.start_new ? '0 : fail_reg;
    assign cur_fail_prev = cls.start_new ? '0 : fail_prev_reg;
    assign cur_last_b    = cls.start_new ? 1'b0 : last_b_reg;
    assign cur_last_d    = cls.start_new ? 1'b0 : last_d_reg;

    assign bin_w = scale_add(cur_bin, rsnp_pkg::RC_BIN, cls.digit);
    assign oct_w = scale_add(cur_oct, rsnp_pkg::RC_OCT, cls.digit);
    assign dec_w = scale_add(cur_dec, rsnp_pkg::RC_DEC, cls.digit);
    assign hex_w = scale_add(cur_hex, rsnp_pkg::RC_HEX, cls.digit);

    // a radix stops on a prior failure, a bad digit or overflow
    assign stop[0] = cur_fail[0] | digit_bad(rsnp_pkg::RC_BIN, cls.digit) | (|bin_w[VB+3:VB]);
    assign stop[1] = cur_fail[1] | digit_bad(rsnp_pkg::RC_OCT, cls.digit) | (|oct_w[VB+3:VB]);
    assign stop[2] = cur_fail[2] | digit_bad(rsnp_pkg::RC_DEC, cls.digit) | (|dec_w[VB+3:VB]);
    assign stop[3] = cur_fail[3] | (|hex_w[VB+3:VB]);

    assign take     = !cls_empty && !res_full;
    assign skip     = !cur_run && cls.is_space;
    assign ending   = !skip && !cls.is_digit;
    assign cls_pop  = take;
    assign res_push = take && ending;

    always_comb
    begin
        if (cls.is_h)
        begin
            sel_v = cur_hex;      sel_ok = !cur_fail[3];      sel_rc = rsnp_pkg::RC_HEX;
            sel_used = 1'b1;
        end
        else if (cls.is_oq)
        begin
            sel_v = cur_oct;      sel_ok = !cur_fail[1];      sel_rc = rsnp_pkg::RC_OCT;
            sel_used = 1'b1;
        end
        else if (cur_run && cur_last_b)
        begin
            sel_v = cur_bin_prev; sel_ok = !cur_fail_prev[0]; sel_rc = rsnp_pkg::RC_BIN;
            sel_used = 1'b0;
        end
        else if (cur_run && cur_last_d)
        begin
            sel_v = cur_dec_prev; sel_ok = !cur_fail_prev[1]; sel_rc = rsnp_pkg::RC_DEC;
            sel_used = 1'b0;
        end
        else
        begin
            sel_v = cur_dec;      sel_ok = !cur_fail[2];      sel_rc = rsnp_pkg::RC_DEC;
            sel_used = 1'b0;
        end
    end

    generate
        if (VB >= OUT_W)
        begin : g_trunc
            assign sel_v16 = sel_v[OUT_W-1:0];
        end
        else
        begin : g_ext
            assign sel_v16 = {{(OUT_W-VB){1'b0}}, sel_v};
        end
    endgenerate

    always_comb
    begin
        res.value         = sel_ok ? sel_v16 : '0;
        res.number_ok     = sel_ok;
        res.radix_code    = sel_rc;
        res.char_consumed = sel_used;
    end

    always_comb
    begin
        run_next       = run_reg;
        bin_acc_next   = bin_acc_reg;
        oct_acc_next   = oct_acc_reg;
        dec_acc_next   = dec_acc_reg;
        hex_acc_next   = hex_acc_reg;
        bin_prev_next  = bin_prev_reg;
        dec_prev_next  = dec_prev_reg;
        fail_next      = fail_reg;
        fail_prev_next = fail_prev_reg;
        last_b_next    = last_b_reg;
        last_d_next    = last_d_reg;
        if (take)
        begin
            if (skip)
            begin
                run_next       = cur_run;
                bin_acc_next   = cur_bin;
                oct_acc_next   = cur_oct;
                dec_acc_next   = cur_dec;
                hex_acc_next   = cur_hex;
                bin_prev_next  = cur_bin_prev;
                dec_prev_next  = cur_dec_prev;
                fail_next      = cur_fail;
                fail_prev_next = cur_fail_prev;
                last_b_next    = cur_last_b;
                last_d_next    = cur_last_d;
            end
            else if (cls.is_digit)
            begin
                run_next       = 1'b1;
                bin_prev_next  = cur_bin;
                dec_prev_next  = cur_dec;
                fail_prev_next = {cur_fail[2], cur_fail[0]};
                last_b_next    = cls.is_b;
                last_d_next    = cls.is_d;
                bin_acc_next   = stop[0] ? cur_bin : bin_w[VB-1:0];
                oct_acc_next   = stop[1] ? cur_oct : oct_w[VB-1:0];
                dec_acc_next   = stop[2] ? cur_dec : dec_w[VB-1:0];
                hex_acc_next   = stop[3] ? cur_hex : hex_w[VB-1:0];
                fail_next      = stop;
            end
            else
            begin
                run_next       = 1'b0;
                bin_acc_next   = '0;
                oct_acc_next   = '0;
                dec_acc_next   = '0;
                hex_acc_next   = '0;
                bin_prev_next  = '0;
                dec_prev_next  = '0;
                fail_next      = '0;
                fail_prev_next = '0;
                last_b_next    = 1'b0;
                last_d_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            bin_acc_reg   <= '0;
            oct_acc_reg   <= '0;
            dec_acc_reg   <= '0;
            hex_acc_reg   <= '0;
            bin_prev_reg  <= '0;
            dec_prev_reg  <= '0;
            fail_reg      <= '0;
            fail_prev_reg <= '0;
            last_b_reg    <= 1'b0;
            last_d_reg    <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            bin_acc_reg   <= bin_acc_next;
            oct_acc_reg   <= oct_acc_next;
            dec_acc_reg   <= dec_acc_next;
            hex_acc_reg   <= hex_acc_next;
            bin_prev_reg  <= bin_prev_next;
            dec_prev_reg  <= dec_prev_next;
            fail_reg      <= fail_next;
            fail_prev_reg <= fail_prev_next;
            last_b_reg    <= last_b_next;
            last_d_reg    <= last_d_next;
        end
    end

endmodule

### hdl/radix_suffix_number_parser_top.sv
// Radix-suffix integer literal parser. Characters enter one per transfer on the
// push/full side; leading spaces are skipped, then a run of 0-9 / A-F is
// collected, and the first other character ends the number with one result on
// the empty/pop side. H selects hex and O or Q octal (char_consumed = 1);
// otherwise a run ending in B is binary and one ending in D is decimal, that
// letter excluded (char_consumed = 0, resume at the ending character). Illegal
// digits or a value above 2^VALUE_BITS-1 give value 0 with number_ok = 0. Set
// start_new on a character to drop any partial number before it. Throughput is
// one character per clock while the result queue has room, with no other stalls
// from the block itself: the back end updates all four radix accumulators
// (shift/add, one per radix) together for each character. A result reaches the
// result ports through two queues: the ending character's transfer writes the
// classified-character queue, and the back end writes the result queue when it takes that character.
module radix_suffix_number_parser_top #(
    parameter int VALUE_BITS = rsnp_pkg::VALUE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // character side
    input  logic                push,
    input  rsnp_pkg::in_item_t  item,
    output logic                full,
    // result side
    output logic                empty,
    input  logic                pop,
    output rsnp_pkg::out_item_t result
);

    rsnp_pkg::cls_item_t cls;
    logic                cls_empty;
    logic                cls_pop;
    rsnp_pkg::out_item_t res;
    logic                res_push;
    logic                res_full;

    // Front: classify each character and queue it
    rsnp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (cls_pop),
        .cls   (cls),
        .empty (cls_empty)
    );

    // Back: per-radix accumulators and result selection
    rsnp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (cls),
        .cls_empty (cls_empty),
        .cls_pop   (cls_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue decouples the back end from the consumer
    rsnp_fifo #(
        .WIDTH ($bits(rsnp_pkg::out_item_t)),
        .DEPTH (rsnp_pkg::QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
